FILE: sv/btree_key_search_macros.svh
// Assertion macros shared by the B-tree key search RTL.
`ifndef BTREE_KEY_SEARCH_MACROS_SVH
`define BTREE_KEY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Checks prop at every rising clock edge outside reset.
`define BKS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("btree_key_search assertion failed");

// Checks prop at every rising clock edge, also during reset.
`define BKS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("btree_key_search assertion failed");

`else

`define BKS_ASSERT(lbl, clk, rst, prop)
`define BKS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: sv/bks_pkg.sv
// Types, constants and codes of the B-tree key search block.
package bks_pkg;

   localparam int MIN_DEGREE = 4;
   localparam int NODE_COUNT = 256;
   localparam int MAX_LEVELS = 8;
   localparam int KEY_BITS   = 32;

   localparam int MAX_KEYS    = 2 * MIN_DEGREE - 1;
   localparam int MAX_KIDS    = 2 * MIN_DEGREE;
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int CNT_W       = $clog2(MAX_KEYS + 1);
   localparam int LEVEL_W     = $clog2(MAX_LEVELS + 1);
   localparam int CHILD_DEPTH = NODE_COUNT * MAX_KIDS;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
   localparam int HDR_W       = CNT_W + 1;

   // Item actions.
   localparam logic [1:0] ACT_HEADER = 2'd0;
   localparam logic [1:0] ACT_KEY    = 2'd1;
   localparam logic [1:0] ACT_CHILD  = 2'd2;
   localparam logic [1:0] ACT_SEARCH = 2'd3;

   // Result status codes.
   localparam logic [1:0] STS_FOUND = 2'd0;
   localparam logic [1:0] STS_MISS  = 2'd1;
   localparam logic [1:0] STS_LIMIT = 2'd2;

   typedef logic signed [KEY_BITS-1:0] key_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         node_index;
      logic [2:0]         slot_index;
      logic signed [31:0] slot_value;
      logic               leaf_flag;
      logic signed [31:0] search_key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] found_node;
      logic [2:0] found_slot;
      logic [3:0] levels_visited;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic       count_level;
      logic       load_child;
      logic       finish;
      logic [1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic level_max;
      logic key_hit;
      logic leaf;
      logic rsp_free;
   } dp_sts_type;

endpackage

FILE: sv/bks_ram.sv
// Generic single-port RAM with registered read.
module bks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bks_ctrl.sv
// Walk controller of the B-tree key search.
`include "btree_key_search_macros.svh"

module bks_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  logic [1:0]          req_action,
   input  bks_pkg::dp_sts_type sts,
   output bks_pkg::dp_cmd_type cmd,
   output logic                busy
);
   import bks_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_LOOKUP  = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;
   localparam logic [1:0] ST_DESCEND = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = STS_MISS;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_action == ACT_SEARCH) begin
               cmd.start = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (sts.level_max) begin
               if (sts.rsp_free) begin
                  cmd.finish = 1'b1;
                  cmd.status = STS_LIMIT;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.count_level = 1'b1;
               state_in        = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (sts.key_hit || sts.leaf) begin
               // Hold here until the output register can take the result.
               if (sts.rsp_free) begin
                  cmd.finish = 1'b1;
                  cmd.status = sts.key_hit ? STS_FOUND : STS_MISS;
                  state_in   = ST_IDLE;
               end
            end else begin
               state_in = ST_DESCEND;
            end
         end
         ST_DESCEND: begin
            cmd.load_child = 1'b1;
            state_in       = ST_LOOKUP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `BKS_ASSERT(a_descend_then_lookup, clock, reset,
               state_ff == ST_DESCEND |=> state_ff == ST_LOOKUP)
   `BKS_ASSERT(a_inner_node_descends, clock, reset,
               (state_ff == ST_COMPARE && !sts.key_hit && !sts.leaf) |=> state_ff == ST_DESCEND)

endmodule

FILE: sv/bks_dpath.sv
// Node store, key compare and result register of the B-tree key search.
`include "btree_key_search_macros.svh"

module bks_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  bks_pkg::req_type    req_data,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  bks_pkg::dp_cmd_type cmd,
   output bks_pkg::dp_sts_type sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bks_pkg::rsp_type    rsp_data
);
   import bks_pkg::*;

   logic [7:0]          root_ff;
   logic [NODE_W-1:0]   walk_node_ff;
   logic [NODE_W-1:0]   walk_node_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic [LEVEL_W-1:0]  level_in;
   key_type             skey_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [NODE_W-1:0]   node_addr;
   logic [CHILD_AW-1:0] child_addr;
   logic                wr_header;
   logic                wr_key;
   logic                wr_child;
   logic [CNT_W-1:0]    wr_count;
   logic [HDR_W-1:0]    hdr_rd;
   logic [CNT_W-1:0]    rd_count;
   logic                rd_leaf;
   key_type             key_rd [MAX_KEYS];
   logic [NODE_W-1:0]   child_rd;
   logic [CNT_W-1:0]    pos;
   logic                hit;

   assign wr_header = req_accept && req_data.action == ACT_HEADER;
   assign wr_key    = req_accept && req_data.action == ACT_KEY;
   assign wr_child  = req_accept && req_data.action == ACT_CHILD;

   // Writes address the node of the item; otherwise the walk node is read.
   assign node_addr  = req_accept ? NODE_W'(req_data.node_index) : walk_node_ff;
   assign child_addr = req_accept
      ? CHILD_AW'(req_data.node_index) * CHILD_AW'(MAX_KIDS) + CHILD_AW'(req_data.slot_index)
      : CHILD_AW'(walk_node_ff) * CHILD_AW'(MAX_KIDS) + CHILD_AW'(pos);

   // Negative counts store as zero, large ones as the node capacity.
   always_comb begin
      if (req_data.slot_value[31]) begin
         wr_count = '0;
      end else if (req_data.slot_value[30:0] > 31'(MAX_KEYS)) begin
         wr_count = CNT_W'(MAX_KEYS);
      end else begin
         wr_count = CNT_W'(req_data.slot_value[30:0]);
      end
   end

   bks_ram #(.WIDTH(HDR_W), .DEPTH(NODE_COUNT)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_header),
      .addr    (node_addr),
      .wr_data ({req_data.leaf_flag, wr_count}),
      .rd_data (hdr_rd)
   );

   assign rd_leaf  = hdr_rd[HDR_W-1];
   assign rd_count = hdr_rd[CNT_W-1:0];

   // One key RAM per slot so that all key slots of a node are read together.
   for (genvar j = 0; j < MAX_KEYS; j++) begin : g_key
      bks_ram #(.WIDTH(KEY_BITS), .DEPTH(NODE_COUNT)) u_key_ram (
         .clock   (clock),
         .wr_en   (wr_key && req_data.slot_index == 3'(j)),
         .addr    (node_addr),
         .wr_data (KEY_BITS'(req_data.slot_value)),
         .rd_data (key_rd[j])
      );
   end

   bks_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
      .clock   (clock),
      .wr_en   (wr_child && 32'(req_data.slot_index) < MAX_KIDS),
      .addr    (child_addr),
      .wr_data (NODE_W'(req_data.slot_value[NODE_W-1:0])),
      .rd_data (child_rd)
   );

   // Position of the first stored key that is not less than the search key.
   always_comb begin
      pos = rd_count;
      hit = 1'b0;
      for (int j = MAX_KEYS - 1; j >= 0; j--) begin
         if (CNT_W'(j) < rd_count && key_rd[j] >= skey_ff) begin
            pos = CNT_W'(j);
            hit = (key_rd[j] == skey_ff);
         end
      end
   end

   always_comb begin
      walk_node_in = walk_node_ff;
      level_in     = level_ff;
      if (cmd.start) begin
         walk_node_in = NODE_W'(root_ff);
         level_in     = '0;
      end else if (cmd.load_child) begin
         walk_node_in = child_rd;
      end
      if (cmd.count_level) begin
         level_in = level_ff + LEVEL_W'(1);
      end
   end

   always_comb begin
      rsp_in                = rsp_ff;
      rsp_in.status         = cmd.status;
      rsp_in.found_node     = '0;
      rsp_in.found_slot     = '0;
      rsp_in.levels_visited = 4'(level_ff);
      if (cmd.status == STS_FOUND) begin
         rsp_in.found_node = 8'(walk_node_ff);
         rsp_in.found_slot = 3'(pos);
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         walk_node_ff <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            root_ff <= csr_wr_data;
         end
         walk_node_ff <= walk_node_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         skey_ff <= KEY_BITS'(req_data.search_key);
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.level_max = (32'(level_ff) >= MAX_LEVELS);
   assign sts.key_hit   = hit;
   assign sts.leaf      = rd_leaf;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BKS_ASSERT(a_finish_needs_room, clock, reset, cmd.finish |-> sts.rsp_free)
   `BKS_ASSERT(a_level_bounded, clock, reset, 32'(level_ff) <= MAX_LEVELS)
   `BKS_ASSERT(a_status_legal, clock, reset,
               rsp_valid_ff |-> (rsp_ff.status == STS_FOUND || rsp_ff.status == STS_MISS ||
                                 rsp_ff.status == STS_LIMIT))

endmodule

FILE: sv/btree_key_search.sv
// Top level of the B-tree key search block.
//
// Write items (node header, key slot, child slot) are taken while no search walks
// and go straight into the node store RAMs. A search item walks down from the
// node held in the root register; each level passes the states LOOKUP, COMPARE
// and DESCEND: the registered read of the node header and all key slots, the key
// compare, and the registered read of the child slot that leads to the next node.
// A walk also stops at the level limit, with status STS_LIMIT. No new item is
// accepted while a search walks, but one is accepted while a finished result
// still waits in the output register.
module btree_key_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bks_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bks_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);
   import bks_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       busy;
   logic       req_accept;

   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;

   bks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_action (req_data.action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   bks_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the B-tree key search block: random trees, searches, root changes.
module testbench;
   import bks_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int ITEM_TARGET  = 1600;
   localparam int DRAIN_CYCLES = 3 * MAX_LEVELS + 4;
   localparam int KEY_LOW      = 32'sh8000_0000;
   localparam int KEY_HIGH     = 32'sh7FFF_FFFF;

   // How often a side holds off before an item.
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_FULL   = 1;
   localparam int IDLE_SPARSE = 2;

   typedef struct packed {
      req_type req;
      logic    has_rsp;
      rsp_type rsp;
   } queued_item_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = '0;

   // Tree model and the flags of which entries have been written.
   key_type           key_mem      [NODE_COUNT*MAX_KEYS];
   logic [NODE_W-1:0] child_mem    [NODE_COUNT*MAX_KIDS];
   int                count_mem    [NODE_COUNT];
   bit                leaf_mem     [NODE_COUNT];
   bit                key_written  [NODE_COUNT*MAX_KEYS];
   bit                child_written[NODE_COUNT*MAX_KIDS];
   bit                head_written [NODE_COUNT];
   logic [7:0]        root_reg = '0;

   queued_item_type req_backlog[$];
   rsp_type         awaited_results[$];
   queued_item_type accepted_item;
   rsp_type         awaited;
   int              phase_keys[$];
   int              item_total    = 0;
   int              error_count   = 0;
   int              cycle_count   = 0;
   int              req_wait      = 0;
   int              rsp_wait      = 0;
   int              req_idle_mode = IDLE_FULL;
   int              rsp_idle_mode = IDLE_FULL;
   bit              req_busy      = 1'b0;

   btree_key_search i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait(input int mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_FULL: return $urandom_range(0, 16);
         default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      endcase
   endfunction

   // Applies one item to the tree model and works out the result of a search.
   // Returns 0 for a search that would read an entry never written; such an
   // item is never sent.
   function automatic bit tree_apply(input req_type r, output logic has_rsp,
                                     output rsp_type rsp);
      int          node, pos, cnt, level, base;
      key_type     skey;
      logic [31:0] uval;
      bit          done;
      has_rsp = 1'b0;
      rsp     = '0;
      uval    = r.slot_value;
      case (r.action)
         ACT_HEADER: begin
            if (r.slot_value < 0)
               count_mem[r.node_index] = 0;
            else if (r.slot_value > MAX_KEYS)
               count_mem[r.node_index] = MAX_KEYS;
            else
               count_mem[r.node_index] = r.slot_value;
            leaf_mem[r.node_index]     = r.leaf_flag;
            head_written[r.node_index] = 1'b1;
         end
         ACT_KEY: begin
            if (r.slot_index < MAX_KEYS) begin
               key_mem[r.node_index * MAX_KEYS + r.slot_index]     = key_type'(r.slot_value);
               key_written[r.node_index * MAX_KEYS + r.slot_index] = 1'b1;
            end
         end
         ACT_CHILD: begin
            if (r.slot_index < MAX_KIDS) begin
               child_mem[r.node_index * MAX_KIDS + r.slot_index] =
                  NODE_W'(uval % NODE_COUNT);
               child_written[r.node_index * MAX_KIDS + r.slot_index] = 1'b1;
            end
         end
         ACT_SEARCH: begin
            has_rsp    = 1'b1;
            skey       = key_type'(r.search_key);
            node       = root_reg % NODE_COUNT;
            level      = 0;
            done       = 1'b0;
            rsp.status = STS_MISS;
            while (!done) begin
               if (level >= MAX_LEVELS) begin
                  rsp.status = STS_LIMIT;
                  done       = 1'b1;
               end else begin
                  level++;
                  if (!head_written[node])
                     return 1'b0;
                  cnt  = count_mem[node];
                  base = node * MAX_KEYS;
                  for (int k = 0; k < cnt; k++)
                     if (!key_written[base + k])
                        return 1'b0;
                  pos = 0;
                  while (pos < cnt && skey > key_mem[base + pos])
                     pos++;
                  if (pos < cnt && skey == key_mem[base + pos]) begin
                     rsp.status     = STS_FOUND;
                     rsp.found_node = node[7:0];
                     rsp.found_slot = pos[2:0];
                     done           = 1'b1;
                  end else if (leaf_mem[node]) begin
                     done = 1'b1;
                  end else begin
                     if (!child_written[node * MAX_KIDS + pos])
                        return 1'b0;
                     node = child_mem[node * MAX_KIDS + pos];
                  end
               end
            end
            rsp.levels_visited = level[3:0];
         end
      endcase
      return 1'b1;
   endfunction

   function automatic void offer(input req_type r);
      queued_item_type entry;
      logic            has_rsp;
      rsp_type         rsp;
      entry.req = r;
      if (tree_apply(r, has_rsp, rsp)) begin
         entry.has_rsp = has_rsp;
         entry.rsp     = rsp;
         req_backlog.push_back(entry);
         // A key write beyond the node's slots is dropped by the block.
         if (!(r.action == ACT_KEY && r.slot_index >= MAX_KEYS))
            item_total++;
      end
   endfunction

   function automatic req_type noise_req();
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   // Fields that the action does not use keep random content.
   function automatic void offer_write(input logic [1:0] action, input int node,
                                       input int slot, input int value, input bit leaf);
      req_type r;
      r            = noise_req();
      r.action     = action;
      r.node_index = node[7:0];
      r.slot_index = slot[2:0];
      r.slot_value = value;
      if (action == ACT_HEADER)
         r.leaf_flag = leaf;
      offer(r);
   endfunction

   function automatic void offer_search(input int key);
      req_type r;
      r            = noise_req();
      r.action     = ACT_SEARCH;
      r.search_key = key;
      offer(r);
   endfunction

   // Writes a tree of up to four tiers under root. The bottom tier is made of
   // leaves, unless the tree is looped back to its root to run into the level
   // limit.
   function automatic void plant_tree(input int depth, input int root);
      int          tier_node[4][3];
      int          tier_size[4];
      int          keys[$];
      int          node, cnt, raw, nt, kid;
      logic [31:0] cval;
      bit          narrow, loopy, leaf;
      narrow = ($urandom_range(0, 1) == 0);
      loopy  = ($urandom_range(0, 4) == 0);
      for (int l = 0; l < depth; l++) begin
         tier_size[l] = (l == 0) ? 1 : $urandom_range(1, 3);
         for (int n = 0; n < tier_size[l]; n++)
            tier_node[l][n] = $urandom_range(0, NODE_COUNT - 1);
      end
      tier_node[0][0] = root;
      for (int l = 0; l < depth; l++) begin
         for (int n = 0; n < tier_size[l]; n++) begin
            node = tier_node[l][n];
            leaf = (l == depth - 1) && !loopy;
            cnt  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, MAX_KEYS);
            raw  = cnt;
            // Counts outside the node capacity are clamped by the block.
            if (cnt == 0 && $urandom_range(0, 2) == 0)
               raw = int'($urandom | 32'h8000_0000);
            if (cnt == MAX_KEYS && $urandom_range(0, 2) == 0)
               raw = $urandom_range(MAX_KEYS + 1, KEY_HIGH);
            offer_write(ACT_HEADER, node, 0, raw, leaf);
            keys.delete();
            for (int k = 0; k < cnt; k++)
               keys.push_back(narrow ? int'($urandom_range(0, 128)) - 64 : int'($urandom));
            if ($urandom_range(0, 7) != 0)
               keys.sort();
            for (int k = 0; k < cnt; k++) begin
               offer_write(ACT_KEY, node, k, keys[k], 1'b0);
               phase_keys.push_back(keys[k]);
            end
            if (!leaf) begin
               nt = (l + 1 < depth) ? l + 1 : 0;
               for (int k = 0; k <= cnt; k++) begin
                  kid  = tier_node[nt][$urandom_range(0, tier_size[nt] - 1)];
                  if ($urandom_range(0, 7) == 0)
                     kid = root;
                  cval = $urandom;
                  cval = ($urandom_range(0, 1) == 0) ? cval - cval % NODE_COUNT + kid : kid;
                  offer_write(ACT_CHILD, node, k, int'(cval), 1'b0);
               end
            end
         end
      end
   endfunction

   task automatic wait_idle();
      while (req_backlog.size() != 0 || awaited_results.size() != 0)
         @(posedge clock);
      // Write items leave no result, so the block may still be storing one.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_root(input int root);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= root[7:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      root_reg     = root[7:0];
   endtask

   // Driver: item bookkeeping at the rising edge, new values at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         accepted_item = req_backlog.pop_front();
         if (accepted_item.has_rsp)
            awaited_results.push_back(accepted_item.rsp);
         req_wait = draw_wait(req_idle_mode);
         req_busy = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (req_wait > 0) begin
            req_wait--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog[0].req;
            req_busy   = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: each drawn stall is spent only while a result is offered.
   always @(negedge clock) begin
      rsp_stall <= (rsp_wait != 0);
      if (rsp_wait != 0 && rsp_valid)
         rsp_wait--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            awaited = awaited_results.pop_front();
            if (rsp_data.status !== awaited.status
                || rsp_data.found_node !== awaited.found_node
                || rsp_data.found_slot !== awaited.found_slot
                || rsp_data.levels_visited !== awaited.levels_visited) begin
               $display("%0t: mismatch, expected status %0d node %0d slot %0d levels %0d, actual status %0d node %0d slot %0d levels %0d",
                        $time, awaited.status, awaited.found_node, awaited.found_slot,
                        awaited.levels_visited, rsp_data.status, rsp_data.found_node,
                        rsp_data.found_slot, rsp_data.levels_visited);
               error_count++;
            end
         end
         rsp_wait = draw_wait(rsp_idle_mode);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[btree_key_search] ERROR");
      $finish;
   end

   initial begin
      int root, depth, n_search, key, round;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on node 0, the root after reset.
      offer_write(ACT_HEADER, 0, 0, -5, 1'b1);
      offer_search(0);
      offer_write(ACT_HEADER, 0, 0, 100, 1'b0);
      offer_write(ACT_KEY, 0, 0, KEY_LOW, 1'b0);
      offer_write(ACT_KEY, 0, 1, -1000, 1'b0);
      offer_write(ACT_KEY, 0, 2, -1, 1'b0);
      offer_write(ACT_KEY, 0, 3, 0, 1'b0);
      offer_write(ACT_KEY, 0, 4, 1, 1'b0);
      offer_write(ACT_KEY, 0, 5, 1000, 1'b0);
      offer_write(ACT_KEY, 0, 6, KEY_HIGH, 1'b0);
      offer_write(ACT_KEY, 0, MAX_KEYS, 12345, 1'b0);
      // Child values keep only their node-index bits.
      offer_write(ACT_CHILD, 0, 0, KEY_LOW, 1'b0);
      offer_write(ACT_CHILD, 0, 1, -1, 1'b0);
      offer_write(ACT_CHILD, 0, 2, NODE_COUNT, 1'b0);
      for (int k = 3; k < MAX_KIDS; k++)
         offer_write(ACT_CHILD, 0, k, KEY_HIGH, 1'b0);
      offer_write(ACT_HEADER, NODE_COUNT - 1, 0, 0, 1'b1);
      offer_search(KEY_LOW);
      offer_search(KEY_HIGH);
      offer_search(0);
      offer_search(-999);
      offer_search(-1001);
      offer_search(12345);

      round = 0;
      while (item_total < ITEM_TARGET) begin
         if (round == 0)
            root = NODE_COUNT - 1;
         else if (round == 1)
            root = 0;
         else
            root = $urandom_range(0, NODE_COUNT - 1);
         set_root(root);
         req_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
         rsp_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
         phase_keys.delete();
         depth = $urandom_range(1, 4);
         plant_tree(depth, root);
         n_search = $urandom_range(30, 80);
         for (int s = 0; s < n_search; s++) begin
            key = (phase_keys.size() != 0)
                  ? phase_keys[$urandom_range(0, phase_keys.size() - 1)] : int'($urandom);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: offer_search(key);
               5, 6:          offer_search(key + (($urandom_range(0, 1) == 0) ? 1 : -1));
               7:             offer_search(int'($urandom));
               8: begin
                  case ($urandom_range(0, 3))
                     0:       offer_search(KEY_LOW);
                     1:       offer_search(KEY_HIGH);
                     2:       offer_search(0);
                     default: offer_search(-1);
                  endcase
               end
               default: offer_write(2'($urandom_range(ACT_HEADER, ACT_CHILD)),
                                    $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 7),
                                    int'($urandom), 1'($urandom_range(0, 1)));
            endcase
         end
         round++;
      end

      wait_idle();
      if (error_count == 0)
         $display("[btree_key_search] OK");
      else
         $display("[btree_key_search] ERROR");
      $finish;
   end

endmodule
